FILE: rtl/core/srq_pkg.sv
// srq_pkg: shared constants, status and kind codes, and the scan control type
// for the stream rank query core. No dependencies.
`timescale 1ns / 1ps

package srq_pkg;

  // Default store depth
  localparam int SRQ_CAPACITY = 256;

  // Payload widths
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int RANK_W   = 9;

  // Rank saturation limit
  localparam logic [RANK_W-1:0] RANK_MAX = 9'd511;

  // Item kinds
  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_QUERY  = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_INSERTED  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FOUND     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

  // Control for the shared compare unit
  typedef struct packed {
    logic clr;  // start a new query
    logic en;   // read data is valid this cycle
  } srq_scan_ctl_t;

endpackage

FILE: rtl/core/srq_in_if.sv
// srq_in_if: input channel (kind, value) with valid/ready handshake.
// Depends on srq_pkg.
`timescale 1ns / 1ps

interface srq_in_if import srq_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic                       kind;
  logic signed [VALUE_W-1:0]  value;

  modport source (output valid, kind, value, input ready);
  modport sink   (input valid, kind, value, output ready);
endinterface

FILE: rtl/core/srq_out_if.sv
// srq_out_if: result channel (status, rank) with valid/ready handshake.
// Depends on srq_pkg.
`timescale 1ns / 1ps

interface srq_out_if import srq_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [STATUS_W-1:0]  status;
  logic [RANK_W-1:0]    rank;

  modport source (output valid, status, rank, input ready);
  modport sink   (input valid, status, rank, output ready);
endinterface

FILE: rtl/core/stream_rank_query_core.sv
// Stream rank query core: bounded multiset of signed values with rank queries.
// Insert, or query on an empty store: sequencer goes straight to finish, which loads
// the result register. Query over n > 0 stored entries: entries 0 .. n-1 are read
// one per cycle into one compare, then drain and finish; the input is taken only in
// idle, and a result held off by out_ch.ready holds the input off as long.
// Reset clears entry count, sequencer and output valid; memory is not cleared.
`timescale 1ns / 1ps

module stream_rank_query_core import srq_pkg::*; #(
  parameter int CAPACITY = SRQ_CAPACITY
) (
  input  logic          clk,
  input  logic          rst_n,
  srq_in_if.sink        in_ch,
  srq_out_if.source     out_ch
);

  localparam int ADDR_W = $clog2(CAPACITY);
  localparam int CNT_W  = $clog2(CAPACITY + 1);

  // sequencer states
  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_DRAIN  = 2'd2;
  localparam logic [1:0] S_FINISH = 2'd3;

  logic [1:0]                state_r, state_nxt;
  logic [CNT_W-1:0]          count_r, count_nxt;
  logic [CNT_W-1:0]          idx_r, idx_nxt;
  logic                      rd_vld_r;
  logic                      is_query_r, is_query_nxt;
  logic [STATUS_W-1:0]       st_r, st_nxt;
  logic signed [VALUE_W-1:0] key_r, key_nxt;

  logic                      out_valid_r;
  logic [STATUS_W-1:0]       out_status_r;
  logic [RANK_W-1:0]         out_rank_r;

  logic                      in_acc;
  logic                      full;
  logic                      we;
  logic                      re;
  logic                      load;
  srq_scan_ctl_t             scan_ctl;
  logic signed [VALUE_W-1:0] rdata;
  logic                      found;
  logic [CNT_W-1:0]          less;
  logic [31:0]               less_ext;
  logic [RANK_W-1:0]         rank_sat;
  logic [STATUS_W-1:0]       res_status;
  logic [RANK_W-1:0]         res_rank;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign full        = (count_r == CNT_W'(CAPACITY));

  // sequencer
  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    idx_nxt      = idx_r;
    is_query_nxt = is_query_r;
    st_nxt       = st_r;
    key_nxt      = key_r;
    we           = 1'b0;
    re           = 1'b0;
    load         = 1'b0;
    scan_ctl     = '0;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_ch.kind == KIND_INSERT) begin
            is_query_nxt = 1'b0;
            state_nxt    = S_FINISH;
            if (full) begin
              st_nxt = ST_FULL;
            end else begin
              we        = 1'b1;
              count_nxt = CNT_W'(count_r + 1'b1);
              st_nxt    = ST_INSERTED;
            end
          end else begin
            is_query_nxt = 1'b1;
            key_nxt      = in_ch.value;
            idx_nxt      = '0;
            scan_ctl.clr = 1'b1;
            state_nxt    = (count_r == '0) ? S_FINISH : S_SCAN;
          end
        end
      end
      S_SCAN: begin
        // one read per cycle, entries 0 .. count-1
        re      = 1'b1;
        idx_nxt = CNT_W'(idx_r + 1'b1);
        if (CNT_W'(idx_r + 1'b1) == count_r) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        // last entry is compared this cycle
        state_nxt = S_FINISH;
      end
      S_FINISH: begin
        if (!out_valid_r || out_ch.ready) begin
          load      = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    scan_ctl.en = rd_vld_r;
  end

  // rank saturates at nine bits
  assign less_ext   = 32'(less);
  assign rank_sat   = (less_ext > 32'(RANK_MAX)) ? RANK_MAX : less_ext[RANK_W-1:0];
  assign res_status = is_query_r ? (found ? ST_FOUND : ST_NOT_FOUND) : st_r;
  assign res_rank   = (is_query_r && found) ? rank_sat : '0;

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      count_r    <= '0;
      idx_r      <= '0;
      rd_vld_r   <= 1'b0;
      is_query_r <= 1'b0;
      st_r       <= ST_INSERTED;
    end else begin
      state_r    <= state_nxt;
      count_r    <= count_nxt;
      idx_r      <= idx_nxt;
      rd_vld_r   <= re;
      is_query_r <= is_query_nxt;
      st_r       <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_status_r <= res_status;
      out_rank_r   <= res_rank;
    end
  end

  assign out_ch.valid  = out_valid_r;
  assign out_ch.status = out_status_r;
  assign out_ch.rank   = out_rank_r;

  srq_store #(
    .DEPTH  (CAPACITY),
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk     (clk),
    .we      (we),
    .waddr   (count_r[ADDR_W-1:0]),
    .wdata   (in_ch.value),
    .re      (re),
    .raddr   (idx_r[ADDR_W-1:0]),
    .rdata_r (rdata)
  );

  srq_scan_unit #(
    .CNT_W (CNT_W)
  ) u_scan (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (scan_ctl),
    .key     (key_r),
    .data    (rdata),
    .found_r (found),
    .less_r  (less)
  );

  // entry count stays within the store
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("entry count beyond capacity");

  // reads only touch written entries
  a_read_written: assert property (@(posedge clk) disable iff (!rst_n)
    re |-> (idx_r < count_r))
    else $error("read of an unwritten entry");

  // the last read data is being compared during drain
  a_drain_data: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DRAIN) |-> rd_vld_r)
    else $error("drain without pending read data");

  // an accepted insert into a non-full store bumps the count by one
  a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_ch.kind == KIND_INSERT) && !full)
      |=> (count_r == CNT_W'($past(count_r) + 1'b1)))
    else $error("insert did not advance entry count");

  // no result is loaded over one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |=> (out_status_r == $past(out_status_r)))
    else $error("pending result overwritten");

endmodule

FILE: rtl/core/srq_store.sv
// srq_store: value memory, one write port and one registered read port.
// Depends on srq_pkg.
`timescale 1ns / 1ps

module srq_store import srq_pkg::*; #(
  parameter int DEPTH  = SRQ_CAPACITY,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [ADDR_W-1:0]          waddr,
  input  logic signed [VALUE_W-1:0]  wdata,
  input  logic                       re,
  input  logic [ADDR_W-1:0]          raddr,
  output logic signed [VALUE_W-1:0]  rdata_r
);

  logic signed [VALUE_W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

FILE: rtl/core/srq_scan_unit.sv
// srq_scan_unit: shared compare unit, one stored entry per beat of read data;
// accumulates found flag and less-than count. Depends on srq_pkg.
`timescale 1ns / 1ps

module srq_scan_unit import srq_pkg::*; #(
  parameter int CNT_W = $clog2(SRQ_CAPACITY + 1)
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  srq_scan_ctl_t              ctl,
  input  logic signed [VALUE_W-1:0]  key,
  input  logic signed [VALUE_W-1:0]  data,
  output logic                       found_r,
  output logic [CNT_W-1:0]           less_r
);

  logic             found_nxt;
  logic [CNT_W-1:0] less_nxt;

  // equal wins over less; duplicates of the key never count
  always_comb begin
    found_nxt = found_r;
    less_nxt  = less_r;
    if (ctl.clr) begin
      found_nxt = 1'b0;
      less_nxt  = '0;
    end else if (ctl.en) begin
      if (data == key) begin
        found_nxt = 1'b1;
      end else if (data < key) begin
        less_nxt = CNT_W'(less_r + 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
      less_r  <= '0;
    end else begin
      found_r <= found_nxt;
      less_r  <= less_nxt;
    end
  end

endmodule

FILE: tb/stream_rank_query_core_tb.sv
// stream_rank_query_core_tb: self-checking bench for the stream rank query core.
// Keeps its own copy of the value multiset to work out each status and rank.
// Depends on srq_pkg, srq_in_if, srq_out_if and stream_rank_query_core.
`timescale 1ns / 1ps

module stream_rank_query_core_tb;
  import srq_pkg::*;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [RANK_W-1:0]   rank;
  } answer_t;

  localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;

  logic clk;
  logic rst_n;

  srq_in_if  in_ch ();
  srq_out_if out_ch ();

  stream_rank_query_core uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Local copy of the multiset
  logic signed [VALUE_W-1:0] held_values [SRQ_CAPACITY];
  int unsigned held_count;

  answer_t pending_answers [$];
  answer_t want;

  int errors;
  int beats_in;
  int beats_out;
  int n_inserted, n_found, n_not_found, n_full;
  int top_rank;

  // Idle controls for the sender task and the ready process
  int send_idle_pct;
  int recv_stall_pct;
  int hold_cycles;

  // 8 ns clock
  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Status and rank for one beat; updates the local multiset
  function automatic answer_t rank_answer(input logic kind,
                                          input logic signed [VALUE_W-1:0] value);
    answer_t a;
    bit seen;
    int unsigned below;
    a.status = ST_INSERTED;
    a.rank   = '0;
    seen     = 1'b0;
    below    = 0;
    if (kind == KIND_INSERT) begin
      if (held_count >= SRQ_CAPACITY) begin
        a.status = ST_FULL;
      end else begin
        held_values[held_count] = value;
        held_count++;
      end
    end else begin
      for (int unsigned k = 0; k < held_count; k++) begin
        if (held_values[k] == value) seen = 1'b1;
        else if (held_values[k] < value) below++;
      end
      if (seen) begin
        a.status = ST_FOUND;
        a.rank   = (below > RANK_MAX) ? RANK_MAX : below[RANK_W-1:0];
      end else begin
        a.status = ST_NOT_FOUND;
      end
    end
    case (a.status)
      ST_INSERTED:  n_inserted++;
      ST_FOUND:     n_found++;
      ST_NOT_FOUND: n_not_found++;
      default:      n_full++;
    endcase
    if (a.status == ST_FOUND && int'(a.rank) > top_rank) top_rank = int'(a.rank);
    return a;
  endfunction

  // Value mix: copies of held values (and near misses), a small band, extremes, full range
  function automatic logic signed [VALUE_W-1:0] pick_value(input bit for_query);
    int roll;
    logic signed [VALUE_W-1:0] v;
    roll = $urandom_range(99);
    if (held_count > 0 && roll < (for_query ? 55 : 25)) begin
      v = held_values[$urandom_range(held_count - 1)];
      if (for_query && $urandom_range(3) == 0) v = $urandom_range(1) ? v + 1 : v - 1;
    end else if (roll < 75) begin
      v = $signed($urandom_range(16)) - 8;
    end else if (roll < 85) begin
      case ($urandom_range(3))
        0:       v = VAL_MIN;
        1:       v = VAL_MAX;
        2:       v = '0;
        default: v = -1;
      endcase
    end else begin
      v = $urandom;
    end
    return v;
  endfunction

  // Offer one beat after a random gap; called and returns at a falling edge
  task automatic send_item(input logic kind, input logic signed [VALUE_W-1:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.kind  <= kind;
    in_ch.value <= value;
    do @(posedge clk); while (!in_ch.ready);
    pending_answers.push_back(rank_answer(kind, value));
    beats_in++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    while (pending_answers.size() != 0) @(negedge clk);
  endtask

  // Receiver: long hold-off when asked, otherwise random stalls
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Result checker
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      beats_out++;
      if (pending_answers.size() == 0) begin
        errors++;
        $display("%0t: unexpected result beat expected=none actual status=%0d rank=%0d",
                 $time, out_ch.status, out_ch.rank);
      end else begin
        want = pending_answers.pop_front();
        if (out_ch.status !== want.status) begin
          errors++;
          $display("%0t: status mismatch expected=%0d actual=%0d",
                   $time, want.status, out_ch.status);
        end
        if (out_ch.rank !== want.rank) begin
          errors++;
          $display("%0t: rank mismatch expected=%0d actual=%0d",
                   $time, want.rank, out_ch.rank);
        end
      end
    end
  end

  // Queries on an empty store never find anything
  task automatic test_empty_store();
    send_item(KIND_QUERY, '0);
    send_item(KIND_QUERY, VAL_MIN);
    send_item(KIND_QUERY, VAL_MAX);
  endtask

  // Extremes, duplicates, found and missing queries
  task automatic test_extreme_values();
    send_item(KIND_INSERT, VAL_MIN);
    send_item(KIND_INSERT, VAL_MAX);
    send_item(KIND_INSERT, '0);
    send_item(KIND_INSERT, -1);
    send_item(KIND_INSERT, 1);
    send_item(KIND_INSERT, '0);
    send_item(KIND_INSERT, 32'sh5555_5555);
    send_item(KIND_INSERT, 32'shAAAA_AAAA);
    send_item(KIND_QUERY, VAL_MIN);
    send_item(KIND_QUERY, VAL_MAX);
    send_item(KIND_QUERY, '0);
    send_item(KIND_QUERY, -1);
    send_item(KIND_QUERY, 1);
    send_item(KIND_QUERY, 2);
    send_item(KIND_QUERY, 32'sh7FFF_FFFE);
    send_item(KIND_QUERY, 32'shAAAA_AAAA);
    send_item(KIND_QUERY, 32'sh8000_0001);
  endtask

  // Random insert/query mix under four idle patterns
  task automatic test_random_traffic();
    int stall_plan [4][2];
    stall_plan = '{'{0, 0}, '{72, 0}, '{0, 72}, '{10, 10}};
    for (int p = 0; p < 4; p++) begin
      send_idle_pct  = stall_plan[p][0];
      recv_stall_pct = stall_plan[p][1];
      for (int i = 0; i < 200; i++) begin
        if ($urandom_range(99) < 35) send_item(KIND_INSERT, pick_value(1'b0));
        else send_item(KIND_QUERY, pick_value(1'b1));
      end
    end
    send_idle_pct  = 0;
    recv_stall_pct = 0;
  endtask

  // Receiver holds off while the sender keeps offering, then the sender waits for all
  task automatic test_output_backpressure();
    hold_cycles = 400;
    for (int i = 0; i < 10; i++) begin
      if (i[0]) send_item(KIND_QUERY, pick_value(1'b1));
      else send_item(KIND_INSERT, pick_value(1'b0));
    end
    in_ch.valid <= 1'b0;
    wait_drained();
  endtask

  // Fill to capacity, refused inserts, and the rank range on a full store
  task automatic test_full_store();
    logic signed [VALUE_W-1:0] lo;
    logic signed [VALUE_W-1:0] hi;
    recv_stall_pct = 30;
    while (held_count < SRQ_CAPACITY) send_item(KIND_INSERT, pick_value(1'b0));
    send_item(KIND_INSERT, VAL_MAX);
    send_item(KIND_INSERT, VAL_MIN);
    send_item(KIND_INSERT, $urandom);
    lo = held_values[0];
    hi = held_values[0];
    for (int k = 1; k < SRQ_CAPACITY; k++) begin
      if (held_values[k] < lo) lo = held_values[k];
      if (held_values[k] > hi) hi = held_values[k];
    end
    send_item(KIND_QUERY, hi);
    send_item(KIND_QUERY, lo);
    send_item(KIND_QUERY, held_values[SRQ_CAPACITY - 1]);
    for (int i = 0; i < 4; i++) send_item(KIND_QUERY, $urandom);
    recv_stall_pct = 0;
  endtask

  // Hard limit on run time
  initial begin
    #20_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // Test sequence
  initial begin
    rst_n       = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.kind  = KIND_INSERT;
    in_ch.value = '0;
    held_count  = 0;
    errors      = 0;
    beats_in    = 0;
    beats_out   = 0;
    n_inserted  = 0;
    n_found     = 0;
    n_not_found = 0;
    n_full      = 0;
    top_rank    = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_cycles    = 0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_empty_store();
    test_extreme_values();
    test_random_traffic();
    test_output_backpressure();
    test_full_store();

    in_ch.valid <= 1'b0;
    wait_drained();
    repeat (SRQ_CAPACITY + 8) @(negedge clk);

    $display("Covered %0d input beats and %0d result beats: %0d inserted, %0d refused full,",
             beats_in, beats_out, n_inserted, n_full);
    $display("%0d queries found (highest rank %0d), %0d not found; %0d errors.",
             n_found, top_rank, n_not_found, errors);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
